/* src/skvl_pkg.sv */
package skvl_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W        = 8;
  localparam int VAL_W        = 32;
  localparam int POS_W        = 4;
  localparam int OPC_W        = 2;
  localparam int CNT_OUT_W    = 5;

  localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPC_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPC_W-1:0] OP_READ   = 2'd2;

  typedef struct packed {
    logic [OPC_W-1:0]        opcode;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } skvl_in_t;

  typedef struct packed {
    logic                    ok;
    logic [KEY_W-1:0]        found_key;
    logic signed [VAL_W-1:0] found_value;
    logic [CNT_OUT_W-1:0]    entry_count;
  } skvl_out_t;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } skvl_entry_t;

  typedef struct packed {
    skvl_entry_t entry;
    logic        lt;
  } skvl_link_t;

  typedef struct packed {
    logic        shift_up;
    logic        shift_down;
    skvl_entry_t entry;
  } skvl_cmd_t;

endpackage

/* src/sorted_key_value_list_unit.sv */
// A start is accepted only while busy is low; the request is registered and is
// executed while busy is high, and out_valid strobes once the result is registered.
// A new start is ignored while busy is high; busy is high for the single
// execute cycle in which every cell of the chain compares and shifts at once.
// Reset clears the entry count, so the list is empty; entry contents are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_key_value_list_unit #(
  parameter int CAPACITY = skvl_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  skvl_pkg::skvl_in_t  in_item,
  output logic                out_valid,
  output skvl_pkg::skvl_out_t out_item
);
  import skvl_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic             busy_r;
  logic             out_valid_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  skvl_in_t         req_r;
  skvl_out_t        out_r;
  skvl_out_t        out_nxt;

  skvl_cmd_t        cmd;
  skvl_link_t       links [CAPACITY];
  logic [CAPACITY-1:0] eqs;
  logic [CAPACITY-1:0] firsts;
  logic [CAPACITY-1:0] hits;

  logic        full;
  logic        any_eq;
  logic        do_ins;
  logic        do_rem;
  logic        do_read;
  skvl_entry_t sel_entry;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      skvl_link_t  prev_l;
      skvl_entry_t next_e;
      logic        occ;

      assign occ = CNT_W'(gi) < count_r;

      if (gi == 0) begin : g_first
        assign prev_l.entry = cmd.entry;
        assign prev_l.lt    = 1'b1;
      end else begin : g_mid
        assign prev_l = links[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign next_e = links[gi].entry;
      end else begin : g_inner
        assign next_e = links[gi+1].entry;
      end

      assign hits[gi] = ((req_r.opcode == OP_REMOVE) && firsts[gi]) ||
                        ((req_r.opcode == OP_READ) && (int'(req_r.position) == gi));

      skvl_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occ        (occ),
        .prev_link  (prev_l),
        .next_entry (next_e),
        .link       (links[gi]),
        .eq         (eqs[gi]),
        .first      (firsts[gi])
      );
    end
  endgenerate

  assign full    = count_r == CNT_W'(CAPACITY);
  assign any_eq  = |eqs;
  assign do_ins  = (req_r.opcode == OP_INSERT) && !full;
  assign do_rem  = (req_r.opcode == OP_REMOVE) && any_eq;
  assign do_read = (req_r.opcode == OP_READ) && (int'(req_r.position) < int'(count_r)) &&
                   (int'(req_r.position) < CAPACITY);

  assign cmd.shift_up     = busy_r && do_ins;
  assign cmd.shift_down   = busy_r && do_rem;
  assign cmd.entry.key    = req_r.key;
  assign cmd.entry.value  = req_r.value;

  always_comb begin
    sel_entry = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hits[i]) begin
        sel_entry = sel_entry | links[i].entry;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_nxt.ok          = do_ins || do_rem || do_read;
    out_nxt.found_key   = '0;
    out_nxt.found_value = '0;
    if (do_rem || do_read) begin
      out_nxt.found_key   = sel_entry.key;
      out_nxt.found_value = sel_entry.value;
    end
    out_nxt.entry_count = CNT_OUT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= busy_r;
      if (busy_r) begin
        busy_r  <= 1'b0;
        count_r <= count_nxt;
      end else if (start) begin
        busy_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      req_r <= in_item;
    end
    if (busy_r) begin
      out_r <= out_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

/* src/skvl_cell.sv */
module skvl_cell (
  input  logic                  clk,
  input  skvl_pkg::skvl_cmd_t   cmd,
  input  logic                  occ,
  input  skvl_pkg::skvl_link_t  prev_link,
  input  skvl_pkg::skvl_entry_t next_entry,
  output skvl_pkg::skvl_link_t  link,
  output logic                  eq,
  output logic                  first
);
  import skvl_pkg::*;

  skvl_entry_t entry_r;
  skvl_entry_t entry_nxt;
  logic        lt;

  assign lt    = occ && (entry_r.key < cmd.entry.key);
  assign eq    = occ && (entry_r.key == cmd.entry.key);
  assign first = eq && prev_link.lt;

  assign link.entry = entry_r;
  assign link.lt    = lt;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.shift_up && !lt) begin
      if (prev_link.lt) begin
        entry_nxt = cmd.entry;
      end else begin
        entry_nxt = prev_link.entry;
      end
    end else if (cmd.shift_down && !lt) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
